### hdl/dtwr_pkg.sv
// ----------------------------------------------------------------------------
// dtwr_pkg
// Types and constants shared by the ranging responder modules.
// ----------------------------------------------------------------------------
package dtwr_pkg;

  localparam int RX_W      = 40;
  localparam int LEN_W     = 10;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int DEN_W     = 34;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [15:0] FRAME_CTRL_EXP = 16'h8841;
  localparam logic [7:0]  FUNC_POLL      = 8'h21;
  localparam logic [7:0]  FUNC_FINAL     = 8'h23;

  localparam logic [15:0]      PAN_RST    = 16'hDECA;
  localparam logic [15:0]      OWN_RST    = 16'h4157;
  localparam logic [15:0]      PEER_RST   = 16'h4556;
  localparam logic [31:0]      DELAY_RST  = 32'h036D8168;
  localparam logic [LEN_W-1:0] MAXLEN_RST = 10'd24;

  localparam logic [CFG_AW-1:0] REG_PAN_ID   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_OWN_ADDR = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PEER     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DELAY    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_LEN  = 3'd4;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_RESP    = 2'd1,
    ACT_DONE    = 2'd2,
    ACT_INVALID = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } fsm_state_t;

  typedef struct packed {
    logic             req_type;
    logic [LEN_W-1:0] frame_length;
    logic [15:0]      frame_control;
    logic [15:0]      dest_pan;
    logic [15:0]      dest_addr;
    logic [15:0]      src_addr;
    logic [7:0]       func_code;
    logic [RX_W-1:0]  rx_time;
    logic [RX_W-1:0]  tx_time;
    logic [31:0]      poll_tx_stamp;
    logic [31:0]      resp_rx_stamp;
    logic [31:0]      final_tx_stamp;
  } in_req_t;

  typedef struct packed {
    action_t            action;
    logic [7:0]         resp_seq;
    logic [31:0]        resp_send_time;
    logic signed [31:0] tof_units;
  } out_req_t;

  typedef struct packed {
    logic capture;
    logic load_prod;
    logic load_div;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_range;
    logic den_zero;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/dtwr_ctrl.sv
// ----------------------------------------------------------------------------
// dtwr_ctrl
// Sequencer of the responder: accepts a request, steps the datapath through
// evaluation, product, division and result delivery.
// ----------------------------------------------------------------------------
module dtwr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtwr_pkg::dp_status_t status,
  output dtwr_pkg::dp_cmd_t    cmd
);
  import dtwr_pkg::*;

  fsm_state_t             state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = status.is_range ? ST_PREP : ST_DONE;
      end
      ST_PREP: begin
        state_nxt = status.den_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    cnt_nxt  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.load_prod = status.is_range;
      end
      ST_PREP: begin
        cmd.load_div = !status.den_zero;
        cnt_nxt      = '0;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      ST_DONE: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/dtwr_dp.sv
// ----------------------------------------------------------------------------
// dtwr_dp
// Datapath of the responder: configuration, frame matching, ranging state,
// stamp products, radix-4 restoring divider and the result register.
// ----------------------------------------------------------------------------
module dtwr_dp #(
  parameter int STAMP_BITS = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dtwr_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [dtwr_pkg::CFG_DW-1:0]       cfg_wdata,
  input  dtwr_pkg::in_req_t                 in_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output dtwr_pkg::out_req_t                out_data,
  input  dtwr_pkg::dp_cmd_t                 cmd,
  output dtwr_pkg::dp_status_t              status
);
  import dtwr_pkg::*;

  localparam int SB_EFF = (STAMP_BITS < RX_W) ? STAMP_BITS : RX_W;
  localparam logic [RX_W-1:0] RX_MASK = ~({RX_W{1'b1}} << SB_EFF);

  logic [15:0]      pan_r, own_r, peer_r;
  logic [31:0]      delay_r;
  logic [LEN_W-1:0] maxlen_r;

  in_req_t          item_r;
  logic             awaiting_r;
  logic [7:0]       seq_r;
  logic [31:0]      poll_rx_r;
  logic [63:0]      p_r, q_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [63:0]      num_r;
  logic [DEN_W-1:0] rem_r;
  logic             out_valid_r;
  out_req_t         out_r;

  logic             good, is_poll, is_range;
  logic [31:0]      ra, rb, da, db;
  logic [DEN_W-1:0] den_nxt;
  logic             p_ge;
  logic [63:0]      mag;
  logic [DEN_W:0]   t1, t2;
  logic             ge1, ge2;
  logic [DEN_W-1:0] r1, r2;
  logic [63:0]      n1, n2;
  logic             big;
  logic [31:0]      tof;
  logic [RX_W:0]    send_sum;
  out_req_t         out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r    <= PAN_RST;
      own_r    <= OWN_RST;
      peer_r   <= PEER_RST;
      delay_r  <= DELAY_RST;
      maxlen_r <= MAXLEN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PAN_ID:   pan_r    <= cfg_wdata[15:0];
        REG_OWN_ADDR: own_r    <= cfg_wdata[15:0];
        REG_PEER:     peer_r   <= cfg_wdata[15:0];
        REG_DELAY:    delay_r  <= cfg_wdata[31:0];
        REG_MAX_LEN:  maxlen_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    good = (item_r.req_type == 1'b0)
        && (item_r.frame_length <= maxlen_r)
        && (item_r.frame_control == FRAME_CTRL_EXP)
        && (item_r.dest_pan == pan_r)
        && (item_r.dest_addr == own_r)
        && (item_r.src_addr == peer_r);
    is_poll  = !awaiting_r && good && (item_r.func_code == FUNC_POLL);
    is_range = awaiting_r && good && (item_r.func_code == FUNC_FINAL);

    ra = item_r.resp_rx_stamp - item_r.poll_tx_stamp;
    rb = item_r.rx_time[31:0] - item_r.tx_time[31:0];
    da = item_r.final_tx_stamp - item_r.resp_rx_stamp;
    db = item_r.tx_time[31:0] - poll_rx_r;
    den_nxt = DEN_W'(ra) + DEN_W'(rb) + DEN_W'(da) + DEN_W'(db);

    p_ge = (p_r >= q_r);
    mag  = p_ge ? (p_r - q_r) : (q_r - p_r);

    t1  = {rem_r, num_r[63]};
    ge1 = (t1 >= {1'b0, den_r});
    r1  = ge1 ? DEN_W'(t1 - {1'b0, den_r}) : t1[DEN_W-1:0];
    n1  = {num_r[62:0], ge1};
    t2  = {r1, n1[63]};
    ge2 = (t2 >= {1'b0, den_r});
    r2  = ge2 ? DEN_W'(t2 - {1'b0, den_r}) : t2[DEN_W-1:0];
    n2  = {n1[62:0], ge2};

    big = |num_r[63:31];
    if (neg_r) begin
      tof = big ? SAT_NEG : (32'd0 - num_r[31:0]);
    end else begin
      tof = big ? SAT_POS : num_r[31:0];
    end

    send_sum = {1'b0, item_r.rx_time & RX_MASK} + (RX_W + 1)'(delay_r);

    out_nxt = '0;
    if (is_range) begin
      if (den_r == '0) begin
        out_nxt.action = ACT_INVALID;
      end else begin
        out_nxt.action    = ACT_DONE;
        out_nxt.tof_units = $signed(tof);
      end
    end else if (is_poll) begin
      out_nxt.action         = ACT_RESP;
      out_nxt.resp_seq       = seq_r;
      out_nxt.resp_send_time = send_sum[39:8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.load_prod) begin
      p_r   <= 64'(ra) * 64'(rb);
      q_r   <= 64'(da) * 64'(db);
      den_r <= den_nxt;
    end
    if (cmd.load_div) begin
      num_r <= mag;
      rem_r <= '0;
      neg_r <= !p_ge;
    end else if (cmd.div_step) begin
      num_r <= n2;
      rem_r <= r2;
    end
    if (cmd.emit) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b0;
      seq_r       <= '0;
      poll_rx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (is_poll) begin
          awaiting_r <= 1'b1;
          seq_r      <= seq_r + 1'b1;
          poll_rx_r  <= item_r.rx_time[31:0];
        end else begin
          awaiting_r <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.is_range = is_range;
  assign status.den_zero = (den_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

### hdl/ds_twr_responder.sv
// ----------------------------------------------------------------------------
// ds_twr_responder
// Responder of double-sided two-way ranging: answers polls and computes the
// time of flight from final frames.
// ----------------------------------------------------------------------------
// Each radio event enters on the in_ channel (valid/stall) and yields exactly
// one result on the out_ channel. A matching poll gives a send-response
// command with sequence number and delayed send time; a matching final frame
// gives the time of flight or, with a zero denominator, a range-invalid code.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata. The
// user must write them only while the block is idle; the block does not enforce it.
// A final frame goes through the stamp products, the difference and the
// divider, which retires two quotient bits per cycle, into the result
// register; any other event goes from evaluation to the result register.
// One request is in flight at a time; a new one is accepted while the last
// result still waits in the output register.
// Reset clears the state machine, the ranging state and the output valid flag,
// and loads the register defaults. A stalled result holds until taken.
// ----------------------------------------------------------------------------
module ds_twr_responder #(
  parameter int STAMP_BITS = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dtwr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [dtwr_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dtwr_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dtwr_pkg::out_req_t          out_data
);
  import dtwr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dtwr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dtwr_dp #(
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### hdl/dtwr_chk.sv
// ----------------------------------------------------------------------------
// dtwr_chk
// Port-level checks of the ranging responder, bound to the top level.
// ----------------------------------------------------------------------------
module dtwr_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input dtwr_pkg::out_req_t   out_data
);
  import dtwr_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_resp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != ACT_RESP |->
      out_data.resp_seq == 8'd0 && out_data.resp_send_time == 32'd0)
    else $error("response fields set without a response");

  a_tof_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != ACT_DONE |-> out_data.tof_units == 32'sd0)
    else $error("time of flight set without a range result");

endmodule

bind ds_twr_responder dtwr_chk u_chk (.*);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the ranging responder against an independent model of its behavior.
// Radio events go in through the request channel with random gaps, results
// are taken with random stall, and each result is compared field by field
// with the oldest prediction. The run starts with hand-picked events at the
// reset settings, then walks through several register settings, extremes
// included, with mostly well-formed poll and final exchanges mixed with
// broken frames, error events and random noise.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtwr_pkg::*;

  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;
  localparam int GAP_MAX         = 9;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 40;
  localparam int TIMEOUT_NS      = 4_000_000;

  class ranging_scoreboard;
    logic [15:0]      pan_id;
    logic [15:0]      own_addr;
    logic [15:0]      peer_addr;
    logic [31:0]      reply_delay;
    logic [LEN_W-1:0] max_len;
    bit               awaiting_final;
    logic [7:0]       seq_count;
    logic [RX_W-1:0]  poll_rx;
    out_req_t         expected_q[$];
    int               errors;

    function new();
      pan_id         = PAN_RST;
      own_addr       = OWN_RST;
      peer_addr      = PEER_RST;
      reply_delay    = DELAY_RST;
      max_len        = MAXLEN_RST;
      awaiting_final = 1'b0;
      seq_count      = '0;
      poll_rx        = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_PAN_ID:   pan_id = val[15:0];
        REG_OWN_ADDR: own_addr = val[15:0];
        REG_PEER:     peer_addr = val[15:0];
        REG_DELAY:    reply_delay = val[31:0];
        REG_MAX_LEN:  max_len = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(in_req_t r);
      out_req_t    e;
      bit          hit;
      logic [31:0] ra, rb, da, db;
      logic [63:0] p, q, den, mag, sum;
      e = '0;
      hit = !r.req_type && r.frame_length <= max_len && r.frame_control == FRAME_CTRL_EXP &&
            r.dest_pan == pan_id && r.dest_addr == own_addr && r.src_addr == peer_addr;
      if (!awaiting_final) begin
        if (hit && r.func_code == FUNC_POLL) begin
          e.action = ACT_RESP;
          e.resp_seq = seq_count;
          sum = 64'(r.rx_time) + 64'(reply_delay);
          e.resp_send_time = sum[39:8];
          poll_rx = r.rx_time;
          seq_count = seq_count + 8'd1;
          awaiting_final = 1'b1;
        end
      end else begin
        awaiting_final = 1'b0;
        if (hit && r.func_code == FUNC_FINAL) begin
          ra = r.resp_rx_stamp - r.poll_tx_stamp;
          rb = r.rx_time[31:0] - r.tx_time[31:0];
          da = r.final_tx_stamp - r.resp_rx_stamp;
          db = r.tx_time[31:0] - poll_rx[31:0];
          p = 64'(ra) * 64'(rb);
          q = 64'(da) * 64'(db);
          den = 64'(ra) + 64'(rb) + 64'(da) + 64'(db);
          if (den == 64'd0) begin
            e.action = ACT_INVALID;
          end else begin
            e.action = ACT_DONE;
            if (p >= q) begin
              mag = (p - q) / den;
              e.tof_units = (mag > 64'h7FFF_FFFF) ? SAT_POS : mag[31:0];
            end else begin
              mag = (q - p) / den;
              e.tof_units = (mag >= 64'h8000_0000) ? SAT_NEG : 32'(32'd0 - mag[31:0]);
            end
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(out_req_t got);
      out_req_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.action !== e.action) begin
        $error("action: expected %0d, actual %0d", e.action, got.action);
        errors++;
      end
      if (got.resp_seq !== e.resp_seq) begin
        $error("resp_seq: expected %0d, actual %0d", e.resp_seq, got.resp_seq);
        errors++;
      end
      if (got.resp_send_time !== e.resp_send_time) begin
        $error("resp_send_time: expected %h, actual %h", e.resp_send_time, got.resp_send_time);
        errors++;
      end
      if (got.tof_units !== e.tof_units) begin
        $error("tof_units: expected %0d, actual %0d", e.tof_units, got.tof_units);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  in_req_t           in_data;
  logic              out_valid;
  logic              out_stall;
  out_req_t          out_data;

  ranging_scoreboard sb;
  bit                rush;

  ds_twr_responder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int draw_gap();
    return rush ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic in_req_t noise_req();
    logic [287:0] w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom};
    return w[$bits(in_req_t)-1:0];
  endfunction

  function automatic in_req_t frame_req(logic [7:0] func);
    in_req_t r;
    r = noise_req();
    r.req_type = 1'b0;
    r.frame_length = LEN_W'($urandom_range(0, sb.max_len));
    r.frame_control = FRAME_CTRL_EXP;
    r.dest_pan = sb.pan_id;
    r.dest_addr = sb.own_addr;
    r.src_addr = sb.peer_addr;
    r.func_code = func;
    return r;
  endfunction

  function automatic in_req_t final_req(logic [31:0] ra, logic [31:0] rb,
                                        logic [31:0] da, logic [31:0] db);
    in_req_t r;
    r = frame_req(FUNC_FINAL);
    r.resp_rx_stamp = r.poll_tx_stamp + ra;
    r.final_tx_stamp = r.resp_rx_stamp + da;
    r.tx_time[31:0] = sb.poll_rx[31:0] + db;
    r.rx_time[31:0] = r.tx_time[31:0] + rb;
    return r;
  endfunction

  function automatic logic [31:0] pick_diff();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_req_t random_final();
    int          tof;
    logic [31:0] da, db;
    tof = $urandom_range(0, 3000);
    da = $urandom_range(1, 1 << 22);
    db = $urandom_range(1, 1 << 22);
    case ($urandom_range(0, 9))
      0: return frame_req(FUNC_FINAL);
      1: return final_req(32'd0, 32'd0, 32'd0, 32'd0);
      2: return final_req(pick_diff(), pick_diff(), pick_diff(), pick_diff());
      3, 4: return final_req($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                             $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20));
      default: return final_req(db + 2 * tof + $urandom_range(0, 15),
                                da + 2 * tof + $urandom_range(0, 15), da, db);
    endcase
  endfunction

  function automatic in_req_t spoil(in_req_t r);
    case ($urandom_range(0, 6))
      0: r.req_type = 1'b1;
      1: begin
        if (sb.max_len != '1) r.frame_length = LEN_W'($urandom_range(sb.max_len + 1, 1023));
        else r.req_type = 1'b1;
      end
      2: r.frame_control ^= 16'(1 << $urandom_range(0, 15));
      3: r.dest_pan ^= 16'(1 << $urandom_range(0, 15));
      4: r.dest_addr ^= 16'(1 << $urandom_range(0, 15));
      5: r.src_addr ^= 16'(1 << $urandom_range(0, 15));
      default: r.func_code ^= 8'(1 << $urandom_range(0, 7));
    endcase
    return r;
  endfunction

  task automatic send(in_req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain(int cycles);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic configure(logic [15:0] pan, logic [15:0] own, logic [15:0] peer,
                           logic [31:0] delay, logic [LEN_W-1:0] maxlen);
    logic [CFG_AW-1:0] idx [6] = '{REG_PAN_ID, REG_OWN_ADDR, REG_PEER,
                                   REG_DELAY, REG_MAX_LEN, REG_UNUSED};
    logic [CFG_DW-1:0] val [6];
    val[0] = {16'($urandom), pan};
    val[1] = {16'($urandom), own};
    val[2] = {16'($urandom), peer};
    val[3] = delay;
    val[4] = {22'($urandom), maxlen};
    val[5] = $urandom;
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      @(negedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    wait (rst_n === 1'b1);
    hold = draw_gap();
    forever begin
      @(negedge clk);
      out_stall <= (hold > 0);
      @(posedge clk);
      if (out_valid) begin
        if (!out_stall) begin
          sb.check_result(out_data);
          hold = draw_gap();
        end else begin
          hold--;
        end
      end
    end
  end

  initial begin
    in_req_t r;
    int      k;
    int      count;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    r = frame_req(FUNC_POLL);
    r.req_type = 1'b1;
    send(r);
    r = frame_req(FUNC_POLL);
    r.frame_length = '1;
    send(r);
    r = frame_req(FUNC_POLL);
    r.frame_length = sb.max_len;
    r.rx_time = '1;
    send(r);
    send(final_req(32'd0, 32'd0, 32'd0, 32'd0));
    r = frame_req(FUNC_POLL);
    r.frame_length = '0;
    r.rx_time = '0;
    send(r);
    send(frame_req(FUNC_POLL));
    send(frame_req(FUNC_POLL));
    send(final_req(32'd1000, 32'd1200, 32'd1100, 32'd900));
    send(frame_req(FUNC_POLL));
    r = final_req(32'd1000, 32'd1200, 32'd1100, 32'd900);
    r.frame_control = ~r.frame_control;
    send(r);
    send(frame_req(FUNC_POLL));
    r = noise_req();
    r.req_type = 1'b1;
    send(r);
    send(frame_req(FUNC_POLL));
    send(final_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0));
    send(frame_req(FUNC_POLL));
    send(final_req(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(frame_req(FUNC_FINAL));
    r = frame_req(FUNC_POLL);
    r.dest_pan = ~r.dest_pan;
    send(r);
    r = frame_req(FUNC_POLL);
    r.dest_addr = ~r.dest_addr;
    send(r);
    r = frame_req(FUNC_POLL);
    r.src_addr = ~r.src_addr;
    send(r);
    send(frame_req(8'hFF));
    send(frame_req(FUNC_POLL));
    r = final_req(32'd5000, 32'd5100, 32'd4900, 32'd4800);
    r.frame_length = '1;
    send(r);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain(SETTLE_CYCLES);
      case (ph)
        0: configure('0, '0, '0, '0, '0);
        1: configure('1, '1, '1, '1, '1);
        default: configure(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                           ($urandom_range(0, 3) == 0) ? 10'h3FF :
                           LEN_W'($urandom_range(0, 1023)));
      endcase
      rush = (ph % 3 == 2);
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        k = $urandom_range(0, 99);
        if (k < 60) begin
          send(frame_req(FUNC_POLL));
          r = random_final();
          if ($urandom_range(0, 6) == 0) r = spoil(r);
          send(r);
          count += 2;
        end else if (k < 70) begin
          send(spoil(frame_req(FUNC_POLL)));
          count++;
        end else if (k < 78) begin
          send(frame_req(FUNC_POLL));
          count++;
        end else if (k < 88) begin
          send(frame_req(8'($urandom)));
          count++;
        end else if (k < 94) begin
          send(noise_req());
          count++;
        end else begin
          r = noise_req();
          r.req_type = 1'b1;
          send(r);
          count++;
        end
      end
    end

    drain(DRAIN_CYCLES);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
